[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rsp_pkg.sv]
// ---------------------------------------------------------------------------
// RESP parser package
// Constants, token kinds, phases and shared types of the RESP stream parser.
// ---------------------------------------------------------------------------
package rsp_pkg;

    localparam int MAX_DEPTH  = 8;
    localparam int COUNT_BITS = 32;
    localparam int LVL_W      = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W      = COUNT_BITS;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [3:0] {
        K_STATUS     = 4'd0,
        K_ERRTEXT    = 4'd1,
        K_BULK       = 4'd2,
        K_STATUS_END = 4'd3,
        K_ERR_END    = 4'd4,
        K_BULK_END   = 4'd5,
        K_INTEGER    = 4'd6,
        K_NIL        = 4'd7,
        K_ARRAY      = 4'd8,
        K_PROTO_ERR  = 4'd9
    } kind_t;

    typedef enum logic [8:0] {
        PH_TYPE    = 9'b000000001,
        PH_TEXT    = 9'b000000010,
        PH_TEXT_CR = 9'b000000100,
        PH_NUM     = 9'b000001000,
        PH_NUM_CR  = 9'b000010000,
        PH_BULK    = 9'b000100000,
        PH_TRAIL1  = 9'b001000000,
        PH_TRAIL2  = 9'b010000000,
        PH_ERROR   = 9'b100000000
    } phase_t;

    typedef enum logic [1:0] {
        TGT_INT   = 2'd0,
        TGT_BULK  = 2'd1,
        TGT_ARRAY = 2'd2
    } target_t;

    // One token as it leaves the parser core
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  text_byte;
        logic [63:0] value;
        logic [3:0]  depth;
        logic        reply_done;
    } token_t;

    // Step result: up to two tokens
    typedef struct packed {
        logic   v0;
        logic   v1;
        token_t t0;
        token_t t1;
    } step_out_t;

endpackage

[hdl/rsp_core.sv]
// ---------------------------------------------------------------------------
// RESP parser core
// Parse state and per-byte next-state logic; registers the step result.
// ---------------------------------------------------------------------------
module rsp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  logic [7:0]         data_byte,
    input  logic               restart,
    output rsp_pkg::step_out_t res
);
    import rsp_pkg::*;

    localparam logic [CNT_W-1:0] LIMIT     = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] LIMIT_D10 = LIMIT / 10;

    phase_t               phase_reg, phase_next;
    logic                 txterr_reg, txterr_next;
    target_t              tgt_reg, tgt_next;
    logic [63:0]          acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    logic                 chars_reg, chars_next;
    logic [CNT_W-1:0]     brem_reg, brem_next;
    logic [CNT_W-1:0]     blen_reg, blen_next;
    logic [CNT_W-1:0]     cnt_reg [MAX_DEPTH];
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic                 cnt_we;
    logic [IDX_W-1:0]     cnt_widx;
    logic [CNT_W-1:0]     cnt_wdata;
    step_out_t            res_next;

    // Finishing an element: find deepest level whose count stays nonzero
    logic [LVL_W-1:0]     fin_lvl;
    logic                 fin_done;
    logic                 fin_dec;
    logic [IDX_W-1:0]     fin_idx;
    logic [MAX_DEPTH-1:0] is_one;

    always_comb
    begin
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            is_one[i] = (cnt_reg[i] == CNT_W'(1));
        end
        fin_lvl  = '0;
        fin_done = 1'b1;
        fin_dec  = 1'b0;
        fin_idx  = '0;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            if ((LVL_W'(i) < lvl_reg) && !is_one[i])
            begin
                fin_lvl  = LVL_W'(i + 1);
                fin_done = 1'b0;
                fin_dec  = 1'b1;
                fin_idx  = IDX_W'(i);
            end
        end
    end

    // Number digit path
    logic [7:0]       dig8;
    logic [3:0]       dig;
    logic             is_dig;
    logic [63:0]      acc_x10;
    logic [CNT_W:0]   cnt_x10;
    logic             too_big;

    assign dig8    = data_byte - CH_ZERO;
    assign dig     = dig8[3:0];
    assign is_dig  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign acc_x10 = (acc_reg << 3) + (acc_reg << 1);
    assign cnt_x10 = (CNT_W+1)'(acc_x10);
    assign too_big = (acc_reg > 64'(LIMIT_D10)) ||
                     (cnt_x10 > ({1'b0, LIMIT} - (CNT_W+1)'(dig)));

    function automatic token_t mk(kind_t k, logic [7:0] t, logic [63:0] v,
                                  logic [LVL_W-1:0] d, logic dn);
        token_t r;
        r.kind       = k;
        r.text_byte  = t;
        r.value      = v;
        r.depth      = 4'(d);
        r.reply_done = dn;
        return r;
    endfunction

    kind_t       tk;
    kind_t       tk_end;
    logic [63:0] signed_v;

    assign tk       = txterr_reg ? K_ERRTEXT : K_STATUS;
    assign tk_end   = txterr_reg ? K_ERR_END : K_STATUS_END;
    assign signed_v = neg_reg ? (64'd0 - acc_reg) : acc_reg;

    // Next-state and token generation
    always_comb
    begin
        phase_next  = phase_reg;
        txterr_next = txterr_reg;
        tgt_next    = tgt_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        chars_next  = chars_reg;
        brem_next   = brem_reg;
        blen_next   = blen_reg;
        lvl_next    = lvl_reg;
        cnt_we      = 1'b0;
        cnt_widx    = fin_idx;
        cnt_wdata   = cnt_reg[fin_idx] - CNT_W'(1);
        res_next    = '0;
        res_next.t0 = mk(K_PROTO_ERR, 8'd0, 64'd0, lvl_reg, 1'b0);
        res_next.t1 = mk(tk, data_byte, 64'd0, lvl_reg, 1'b0);
        if (restart)
        begin
            phase_next = PH_TYPE;
            lvl_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    priority if (data_byte == CH_PLUS || data_byte == CH_MINUS)
                    begin
                        txterr_next = (data_byte == CH_MINUS);
                        phase_next  = PH_TEXT;
                    end
                    else if (data_byte == CH_COLON || data_byte == CH_DOLLAR ||
                             data_byte == CH_STAR)
                    begin
                        tgt_next   = (data_byte == CH_COLON) ? TGT_INT :
                                     (data_byte == CH_DOLLAR) ? TGT_BULK : TGT_ARRAY;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        chars_next = 1'b0;
                        phase_next = PH_NUM;
                    end
                    else
                    begin
                        phase_next  = PH_ERROR;
                        res_next.v0 = 1'b1;
                    end
                end
                PH_TEXT:
                begin
                    if (data_byte == CH_CR)
                    begin
                        phase_next = PH_TEXT_CR;
                    end
                    else
                    begin
                        res_next.v0 = 1'b1;
                        res_next.t0 = mk(tk, data_byte, 64'd0, lvl_reg, 1'b0);
                    end
                end
                PH_TEXT_CR:
                begin
                    res_next.v0 = 1'b1;
                    if (data_byte == CH_LF)
                    begin
                        res_next.t0 = mk(tk_end, 8'd0, 64'd0, lvl_reg, fin_done);
                        cnt_we      = fin_dec;
                        lvl_next    = fin_lvl;
                        phase_next  = PH_TYPE;
                    end
                    else
                    begin
                        res_next.t0 = mk(tk, CH_CR, 64'd0, lvl_reg, 1'b0);
                        if (data_byte != CH_CR)
                        begin
                            res_next.v1 = 1'b1;
                            phase_next  = PH_TEXT;
                        end
                    end
                end
                PH_NUM:
                begin
                    priority if (data_byte == CH_MINUS && !neg_reg && !chars_reg)
                    begin
                        neg_next = 1'b1;
                    end
                    else if (data_byte == CH_CR)
                    begin
                        if (!chars_reg)
                        begin
                            phase_next  = PH_ERROR;
                            res_next.v0 = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_NUM_CR;
                        end
                    end
                    else if (!is_dig || (tgt_reg != TGT_INT && too_big))
                    begin
                        phase_next  = PH_ERROR;
                        res_next.v0 = 1'b1;
                    end
                    else
                    begin
                        acc_next   = acc_x10 + 64'(dig);
                        chars_next = 1'b1;
                    end
                end
                PH_NUM_CR:
                begin
                    phase_next  = PH_TYPE;
                    res_next.v0 = 1'b1;
                    priority if (data_byte != CH_LF)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else if (tgt_reg == TGT_INT)
                    begin
                        res_next.t0 = mk(K_INTEGER, 8'd0, signed_v, lvl_reg, fin_done);
                        cnt_we      = fin_dec;
                        lvl_next    = fin_lvl;
                    end
                    else if (neg_reg && acc_reg != 64'd0)
                    begin
                        if (acc_reg == 64'd1)
                        begin
                            res_next.t0 = mk(K_NIL, 8'd0, 64'd0, lvl_reg, fin_done);
                            cnt_we      = fin_dec;
                            lvl_next    = fin_lvl;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                        end
                    end
                    else if (tgt_reg == TGT_BULK)
                    begin
                        res_next.v0 = 1'b0;
                        blen_next   = CNT_W'(acc_reg);
                        brem_next   = CNT_W'(acc_reg);
                        phase_next  = (acc_reg != 64'd0) ? PH_BULK : PH_TRAIL1;
                    end
                    else if (tgt_reg != TGT_ARRAY)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else if (acc_reg == 64'd0)
                    begin
                        res_next.t0 = mk(K_ARRAY, 8'd0, 64'd0, lvl_reg, fin_done);
                        cnt_we      = fin_dec;
                        lvl_next    = fin_lvl;
                    end
                    else if (lvl_reg >= LVL_W'(MAX_DEPTH))
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        res_next.t0 = mk(K_ARRAY, 8'd0, acc_reg, lvl_reg, 1'b0);
                        cnt_we      = 1'b1;
                        cnt_widx    = IDX_W'(lvl_reg);
                        cnt_wdata   = CNT_W'(acc_reg);
                        lvl_next    = lvl_reg + LVL_W'(1);
                    end
                end
                PH_BULK:
                begin
                    res_next.v0 = 1'b1;
                    res_next.t0 = mk(K_BULK, data_byte, 64'd0, lvl_reg, 1'b0);
                    brem_next   = brem_reg - CNT_W'(1);
                    if (brem_reg == CNT_W'(1))
                    begin
                        phase_next = PH_TRAIL1;
                    end
                end
                PH_TRAIL1:
                begin
                    phase_next = PH_TRAIL2;
                end
                PH_TRAIL2:
                begin
                    res_next.v0 = 1'b1;
                    res_next.t0 = mk(K_BULK_END, 8'd0, 64'(blen_reg), lvl_reg, fin_done);
                    cnt_we      = fin_dec;
                    lvl_next    = fin_lvl;
                    phase_next  = PH_TYPE;
                end
                PH_ERROR:
                begin
                    phase_next = PH_ERROR;
                end
                default:
                begin
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

    // State and step result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            txterr_reg <= 1'b0;
            tgt_reg    <= TGT_INT;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            chars_reg  <= 1'b0;
            brem_reg   <= '0;
            blen_reg   <= '0;
            lvl_reg    <= '0;
            res        <= '0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            txterr_reg <= txterr_next;
            tgt_reg    <= tgt_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            chars_reg  <= chars_next;
            brem_reg   <= brem_next;
            blen_reg   <= blen_next;
            lvl_reg    <= lvl_next;
            res        <= res_next;
        end
        else
        begin
            res.v0 <= 1'b0;
            res.v1 <= 1'b0;
        end
    end

    // Pending counts (no reset needed)
    always_ff @(posedge clk)
    begin
        if (step_en && cnt_we)
        begin
            cnt_reg[cnt_widx] <= cnt_wdata;
        end
    end

endmodule

[hdl/rsp_outq.sv]
// ---------------------------------------------------------------------------
// RESP parser output queue
// Four-entry token FIFO that decouples the parser from the output beat.
// ---------------------------------------------------------------------------
module rsp_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  rsp_pkg::step_out_t res,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output rsp_pkg::token_t    head,
    output logic               head_last
);
    import rsp_pkg::*;

    localparam int QD = 4;

    token_t     q_reg [QD];
    logic       ql_reg [QD];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic       pop;
    logic [1:0] n_push;
    logic [1:0] wr1;

    assign pop       = out_valid && out_ready;
    assign n_push    = 2'(res.v0) + 2'(res.v1);
    assign wr1       = wr_reg + 2'd1;
    assign out_valid = (cnt_reg != 3'd0);
    assign head      = q_reg[rd_reg];
    assign head_last = ql_reg[rd_reg];
    // Two pushes per step plus the one in flight must always fit
    assign room      = (cnt_reg + 3'(n_push) - 3'(pop)) <= 3'(QD - 2);

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_reg + 2'(pop);
            wr_reg  <= wr_reg + n_push;
            cnt_reg <= cnt_reg + 3'(n_push) - 3'(pop);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (res.v0)
        begin
            q_reg[wr_reg]  <= res.t0;
            ql_reg[wr_reg] <= !res.v1;
        end
        if (res.v1)
        begin
            q_reg[wr1]  <= res.t1;
            ql_reg[wr1] <= 1'b1;
        end
    end

endmodule

[hdl/resp_stream_parser.sv]
// ---------------------------------------------------------------------------
// RESP stream parser
// Byte-serial RESP2 reply parser emitting one token per output beat.
// ---------------------------------------------------------------------------
// One stream byte is taken per cycle when ready is high; each byte passes
// the registered parse step and its zero, one or two tokens enter a
// four-entry output queue. Sustained rate is one byte per cycle while
// tokens are drained; ready drops only when the queue could not hold the
// tokens of the next byte. The pending element counts of nested arrays live
// in a small register stack; entries are only read after being written.
module resp_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [7:0]  text_byte,
    output logic [63:0] value,
    output logic [3:0]  depth,
    output logic        reply_done,
    output logic        last_of_step
);
    import rsp_pkg::*;

    step_out_t res;
    token_t    head;
    logic      room;
    logic      step_en;

    assign in_ready = room;
    assign step_en  = in_valid && in_ready;

    rsp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .data_byte (data_byte),
        .restart   (restart),
        .res       (res)
    );

    rsp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head),
        .head_last (last_of_step)
    );

    assign kind       = head.kind;
    assign text_byte  = head.text_byte;
    assign value      = head.value;
    assign depth      = head.depth;
    assign reply_done = head.reply_done;

endmodule

[hdl/rsp_checker.sv]
// ---------------------------------------------------------------------------
// RESP parser port checker
// Port-level assertions on the output stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  kind,
    input logic [7:0]  text_byte,
    input logic        reply_done,
    input logic        last_of_step
);
    import rsp_pkg::*;

    // Stalled output beat stays valid and keeps its kind
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind), "output beat changed while stalled")
    // Kind stays within the defined codes
    `ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, kind <= K_PROTO_ERR, "kind code out of range")
    // Non-text tokens carry no text byte
    `ASSERT_IMPL(a_text_zero, clk, rst_n, out_valid && kind > K_BULK, text_byte == 8'd0, "text byte on a non-text token")
    // Reply completion only on a closing token and only at the end of a step
    `ASSERT_IMPL(a_done_last, clk, rst_n, out_valid && reply_done, last_of_step && kind > K_BULK && kind != K_PROTO_ERR, "reply_done on an invalid token")

endmodule

bind resp_stream_parser rsp_checker u_rsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .text_byte    (text_byte),
    .reply_done   (reply_done),
    .last_of_step (last_of_step)
);

[tb/sv/tb_top.sv]
// ---------------------------------------------------------------------------
// RESP stream parser testbench
// Drives stream bytes through the valid/ready input, predicts each token with
// a behavioral parser model and checks every output beat field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import rsp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    // Expected token with its step marker
    typedef struct {
        logic [3:0]  kind;
        logic [7:0]  text_byte;
        logic [63:0] value;
        logic [3:0]  depth;
        logic        reply_done;
        logic        last_of_step;
    } token_exp_t;

    // Directed row: byte, restart, typed token count (-1 = use model only)
    typedef struct {
        logic [7:0] b;
        logic       rs;
        int         n_typed;
        logic [3:0] k0;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        restart;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  kind;
    logic [7:0]  text_byte;
    logic [63:0] value;
    logic [3:0]  depth;
    logic        reply_done;
    logic        last_of_step;

    resp_stream_parser DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .restart(restart),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .text_byte(text_byte), .value(value), .depth(depth),
        .reply_done(reply_done), .last_of_step(last_of_step)
    );

    // Parser model state
    phase_t      m_phase;
    logic        m_is_err;
    target_t     m_target;
    logic [63:0] m_accum;
    logic        m_neg;
    logic        m_seen_digit;
    logic [63:0] m_bulk_left;
    logic [63:0] m_bulk_len;
    logic [63:0] m_pending [MAX_DEPTH];
    int          m_level;

    token_exp_t  token_q[$];
    token_exp_t  step_toks[$];
    int          fails;
    int          tokens_seen;
    int          bytes_sent;
    int          cycles = 0;
    bit          no_idle;

    // Beat counted against the enclosing arrays; returns reply-complete flag
    function automatic logic close_element();
        while (m_level > 0) begin
            m_pending[m_level - 1] = m_pending[m_level - 1] - 1;
            if (m_pending[m_level - 1] != 0)
                return 1'b0;
            m_level--;
        end
        return 1'b1;
    endfunction

    function automatic void emit(logic [3:0] k, logic [7:0] t, logic [63:0] v,
                                 int d, logic done);
        token_exp_t e;
        e.kind = k;
        e.text_byte = t;
        e.value = v;
        e.depth = d[3:0];
        e.reply_done = done;
        e.last_of_step = 1'b0;
        step_toks.push_back(e);
    endfunction

    function automatic void go_fault();
        m_phase = PH_ERROR;
        emit(K_PROTO_ERR, 8'h00, 64'd0, m_level, 1'b0);
    endfunction

    function automatic void begin_number(target_t t);
        m_target = t;
        m_accum = 0;
        m_neg = 0;
        m_seen_digit = 0;
        m_phase = PH_NUM;
    endfunction

    function automatic void end_number();
        int d;
        logic [63:0] v;
        logic done;
        d = m_level;
        v = m_neg ? (64'd0 - m_accum) : m_accum;
        m_phase = PH_TYPE;
        if (m_target == TGT_INT) begin
            done = close_element();
            emit(K_INTEGER, 8'h00, v, d, done);
        end
        else if (m_neg && m_accum != 0) begin
            if (m_accum == 1) begin
                done = close_element();
                emit(K_NIL, 8'h00, 64'd0, d, done);
            end
            else
                go_fault();
        end
        else if (m_target == TGT_BULK) begin
            m_bulk_len = m_accum;
            m_bulk_left = m_accum;
            m_phase = (m_accum != 0) ? PH_BULK : PH_TRAIL1;
        end
        else if (m_accum == 0) begin
            done = close_element();
            emit(K_ARRAY, 8'h00, 64'd0, d, done);
        end
        else if (m_level >= MAX_DEPTH)
            go_fault();
        else begin
            m_pending[m_level] = m_accum;
            m_level++;
            emit(K_ARRAY, 8'h00, m_accum, d, 1'b0);
        end
    endfunction

    function automatic void number_char(logic [7:0] b);
        logic [63:0] dig;
        logic [63:0] lim;
        if (b == CH_MINUS && !m_neg && !m_seen_digit)
            m_neg = 1;
        else if (b == CH_CR) begin
            if (!m_seen_digit)
                go_fault();
            else
                m_phase = PH_NUM_CR;
        end
        else if (b < CH_ZERO || b > CH_NINE)
            go_fault();
        else begin
            dig = 64'(b - CH_ZERO);
            lim = (64'd1 << COUNT_BITS) - 1;
            if (m_target != TGT_INT &&
                (m_accum > lim / 10 || m_accum * 10 > lim - dig))
                go_fault();
            else begin
                m_accum = m_accum * 10 + dig;
                m_seen_digit = 1;
            end
        end
    endfunction

    // Advance the model by one byte; tokens land in step_toks
    function automatic void parse_byte(logic [7:0] b, logic rs);
        logic [3:0] k;
        int d;
        logic done;
        step_toks.delete();
        k = {3'b000, m_is_err};
        if (rs) begin
            m_phase = PH_TYPE;
            m_level = 0;
            return;
        end
        case (m_phase)
            PH_TYPE:
                if (b == CH_PLUS || b == CH_MINUS) begin
                    m_is_err = (b == CH_MINUS);
                    m_phase = PH_TEXT;
                end
                else if (b == CH_COLON) begin_number(TGT_INT);
                else if (b == CH_DOLLAR) begin_number(TGT_BULK);
                else if (b == CH_STAR) begin_number(TGT_ARRAY);
                else go_fault();
            PH_TEXT:
                if (b == CH_CR) m_phase = PH_TEXT_CR;
                else emit(k, b, 64'd0, m_level, 1'b0);
            PH_TEXT_CR:
                if (b == CH_LF) begin
                    d = m_level;
                    done = close_element();
                    m_phase = PH_TYPE;
                    emit(k + 4'd3, 8'h00, 64'd0, d, done);
                end
                else begin
                    emit(k, CH_CR, 64'd0, m_level, 1'b0);
                    if (b != CH_CR) begin
                        emit(k, b, 64'd0, m_level, 1'b0);
                        m_phase = PH_TEXT;
                    end
                end
            PH_NUM: number_char(b);
            PH_NUM_CR:
                if (b == CH_LF) end_number();
                else go_fault();
            PH_BULK: begin
                emit(K_BULK, b, 64'd0, m_level, 1'b0);
                m_bulk_left = m_bulk_left - 1;
                if (m_bulk_left == 0) m_phase = PH_TRAIL1;
            end
            PH_TRAIL1: m_phase = PH_TRAIL2;
            PH_TRAIL2: begin
                d = m_level;
                done = close_element();
                m_phase = PH_TYPE;
                emit(K_BULK_END, 8'h00, m_bulk_len, d, done);
            end
            default: ;
        endcase
        if (step_toks.size() > 0)
            step_toks[step_toks.size() - 1].last_of_step = 1'b1;
    endfunction

    // Clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output side: random stalls, compare each beat with the oldest token
    always @(posedge clk)
    begin
        token_exp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            tokens_seen++;
            if (token_q.size() == 0)
            begin
                $error("unexpected token kind=%0d", kind);
                fails++;
            end
            else
            begin
                e = token_q.pop_front();
                if (kind !== e.kind)
                begin
                    $error("kind exp %0d got %0d", e.kind, kind); fails++;
                end
                if (text_byte !== e.text_byte)
                begin
                    $error("text_byte exp %h got %h", e.text_byte, text_byte); fails++;
                end
                if (value !== e.value)
                begin
                    $error("value exp %0d got %0d", $signed(e.value), $signed(value));
                    fails++;
                end
                if (depth !== e.depth)
                begin
                    $error("depth exp %0d got %0d", e.depth, depth); fails++;
                end
                if (reply_done !== e.reply_done)
                begin
                    $error("reply_done exp %0b got %0b", e.reply_done, reply_done);
                    fails++;
                end
                if (last_of_step !== e.last_of_step)
                begin
                    $error("last_of_step exp %0b got %0b", e.last_of_step, last_of_step);
                    fails++;
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (no_idle)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Send one byte: optional idle burst, then hold valid until accepted
    task automatic send_byte(logic [7:0] b, logic rs);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        restart <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        parse_byte(b, rs);
        foreach (step_toks[i]) token_q.push_back(step_toks[i]);
        bytes_sent++;
    endtask

    task automatic send_str(string s);
        foreach (s[i]) send_byte(s[i], 1'b0);
    endtask

    task automatic send_num(longint v);
        send_str($sformatf("%0d\r\n", v));
    endtask

    // Random well-formed element, sometimes with injected faults
    task automatic send_element(int lvl);
        int sel;
        int n;
        sel = $urandom_range(0, 9);
        if (sel <= 1)
        begin
            send_byte(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n)
                send_byte(($urandom_range(0, 5) == 0) ? CH_CR : 8'($urandom), 1'b0);
            send_str("\r\n");
        end
        else if (sel <= 3)
        begin
            send_byte(CH_COLON, 1'b0);
            if ($urandom_range(0, 3) == 0)
                send_str("-9223372036854775808123");
            else
                send_str($sformatf("%0d", $signed({$urandom, $urandom}) >>> $urandom_range(0, 63)));
            send_str("\r\n");
        end
        else if (sel <= 5)
        begin
            send_byte(CH_DOLLAR, 1'b0);
            n = ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 5);
            send_num(n);
            repeat ((n < 0) ? 0 : n + 2) send_byte(8'($urandom), 1'b0);
        end
        else if (sel <= 8 && lvl < MAX_DEPTH + 1)
        begin
            send_byte(CH_STAR, 1'b0);
            n = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, 3);
            send_num(n);
            if (n > 0 && m_phase != PH_ERROR)
                repeat (n) send_element(lvl + 1);
        end
        else
        begin
            // Noise: random byte in any phase, then sometimes recover with a restart
            send_byte(8'($urandom), 1'b0);
            if ($urandom_range(0, 1) != 0) send_byte(8'h00, 1'b1);
        end
    endtask

    row_t rows[$];
    initial
    begin
        fails = 0; tokens_seen = 0; bytes_sent = 0; no_idle = 0;
        rst_n = 1'b0; in_valid = 1'b0; data_byte = 8'h00; restart = 1'b0;
        m_phase = PH_TYPE; m_is_err = 0; m_target = TGT_INT; m_accum = 0;
        m_neg = 0; m_seen_digit = 0; m_bulk_left = 0; m_bulk_len = 0; m_level = 0;
        foreach (m_pending[i]) m_pending[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: bad type, restart, extremes; typed kinds checked too
        rows = '{
            '{8'h00, 1'b0, 1, K_PROTO_ERR}, '{8'hFF, 1'b0, 0, K_PROTO_ERR},
            '{8'hFF, 1'b1, 0, K_PROTO_ERR}, '{CH_PLUS, 1'b0, 0, K_STATUS},
            '{8'hFF, 1'b0, 1, K_STATUS}, '{CH_CR, 1'b0, 0, K_STATUS},
            '{8'h00, 1'b0, 2, K_STATUS}, '{CH_CR, 1'b0, 0, K_STATUS},
            '{CH_CR, 1'b0, 1, K_STATUS}, '{CH_LF, 1'b0, 1, K_STATUS_END},
            '{CH_STAR, 1'b0, 0, K_ARRAY}, '{CH_ZERO, 1'b0, 0, K_ARRAY},
            '{CH_CR, 1'b0, 0, K_ARRAY}, '{CH_LF, 1'b0, 1, K_ARRAY},
            '{CH_DOLLAR, 1'b0, 0, K_NIL}, '{CH_MINUS, 1'b0, 0, K_NIL},
            '{CH_CR, 1'b0, 1, K_PROTO_ERR}, '{CH_COLON, 1'b1, 0, K_NIL},
            '{CH_COLON, 1'b0, 0, K_NIL}, '{CH_NINE, 1'b0, 0, K_NIL},
            '{CH_CR, 1'b0, 0, K_NIL}, '{8'h41, 1'b0, 1, K_PROTO_ERR}
        };
        foreach (rows[i])
        begin
            send_byte(rows[i].b, rows[i].rs);
            if (rows[i].n_typed >= 0 && step_toks.size() != rows[i].n_typed)
            begin
                $error("table row %0d token count exp %0d got %0d", i,
                       rows[i].n_typed, step_toks.size());
                fails++;
            end
            else if (rows[i].n_typed >= 1 && step_toks[0].kind != rows[i].k0)
            begin
                $error("table row %0d kind exp %0d got %0d", i, rows[i].k0,
                       step_toks[0].kind);
                fails++;
            end
        end
        send_byte(8'h00, 1'b1);

        // Directed sequences: deep nesting, count overflow, -2 length, -0, -1 array
        repeat (MAX_DEPTH) send_str("*1\r\n");
        send_str("*1\r\n");
        send_byte(8'h00, 1'b1);
        send_str("$4294967296\r\n");
        send_byte(8'h00, 1'b1);
        send_str("$4294967295\r\n");
        send_byte(8'h00, 1'b1);
        send_str("*-2\r\n");
        send_byte(8'h00, 1'b1);
        send_str("$-0\r\n\r\n*-1\r\n:-\r\n");
        send_byte(8'h00, 1'b1);
        send_str(":1-\r\n");
        send_byte(8'h00, 1'b1);
        send_str(":5\rX");
        send_byte(8'h00, 1'b1);

        // Sender pause until all results have drained
        in_valid <= 1'b0;
        while (token_q.size() != 0) @(posedge clk);

        // Random part
        while (bytes_sent < 1200)
        begin
            if (bytes_sent > 1000) no_idle = 1;
            send_element(0);
            if (m_phase != PH_TYPE || m_level != 0) send_byte(8'h00, 1'b1);
        end
        in_valid <= 1'b0;
        while (token_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes covering text, numbers, bulk, nesting and faults;",
                 bytes_sent);
        $display("checked %0d tokens.", tokens_seen);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
